// ===== hdl/orle_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered record list engine package
// Shared action and status codes and the controller state type.
// ----------------------------------------------------------------------------
package orle_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_READOUT = 3'd1,
    ACT_FIND    = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_INSERT  = 3'd4,
    ACT_REVERSE = 3'd5,
    ACT_NOP6    = 3'd6,
    ACT_NOP7    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REV_RD,
    S_REV_WR,
    S_OUT_RD,
    S_OUT_EMIT,
    S_DONE
  } state_e;

  localparam int unsigned KeyW = 32;
  localparam int unsigned AgeW = 8;
  localparam int unsigned NameLowW = 64;
  localparam int unsigned NameMidW = 64;
  localparam int unsigned NameHighW = 32;

endpackage

// ===== hdl/ordered_record_list_engine.sv =====
// ----------------------------------------------------------------------------
// Ordered record list engine
// A bounded list of records kept in a slot memory and an order memory.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Each result is
// shown for one cycle with result_valid_o, and the receiver cannot stall.
// Append writes its order entry and record without a scan. Unused actions and
// errors found at the start go straight to the result. Find, remove and sorted
// insert read one order entry and then its record for each entry visited.
// Insert and remove then move one order entry a cycle. Reverse swaps pairs
// from the ends inward. Read-out reads each entry and its record, then gives
// one result. The longest items are a find that misses, a remove of the tail
// entry or a read-out of a full list. No clearing pass is needed after reset.
module ordered_record_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned NAME_BYTES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic signed [31:0] key_in_i,
  input  logic [7:0]  age_in_i,
  input  logic [63:0] name_in_0_7_i,
  input  logic [63:0] name_in_8_15_i,
  input  logic [31:0] name_in_16_19_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] key_out_o,
  output logic [7:0]  age_out_o,
  output logic [63:0] name_out_0_7_o,
  output logic [63:0] name_out_8_15_o,
  output logic [31:0] name_out_16_19_o,
  output logic        last_item_o,
  output logic [4:0]  stored_count_o,
  output logic        is_empty_o
);
  import orle_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned RecW = KeyW + AgeW + NameLowW + NameMidW + NameHighW;
  localparam int unsigned LowB = (NAME_BYTES >= 8) ? 8 : NAME_BYTES;
  localparam int unsigned MidB = (NAME_BYTES >= 16) ? 8 :
                                 ((NAME_BYTES > 8) ? NAME_BYTES - 8 : 0);
  localparam int unsigned HighB = (NAME_BYTES > 16) ? NAME_BYTES - 16 : 0;
  localparam logic [NameLowW-1:0] LowMask =
    (LowB >= 8) ? '1 : ((NameLowW'(1) << (8 * LowB)) - NameLowW'(1));
  localparam logic [NameMidW-1:0] MidMask =
    (MidB >= 8) ? '1 : ((NameMidW'(1) << (8 * MidB)) - NameMidW'(1));
  localparam logic [NameHighW-1:0] HighMask =
    (HighB >= 4) ? '1 : ((NameHighW'(1) << (8 * HighB)) - NameHighW'(1));

  logic [RecW-1:0] rec_mem [CAPACITY];
  logic [IdxW-1:0] ord_mem [CAPACITY];

  state_e state_q, state_d;
  action_e act_q, act_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] pos2_q, pos2_d;
  logic [IdxW-1:0] tmp_q, tmp_d;
  logic [IdxW-1:0] new_slot_q, new_slot_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [RecW-1:0] in_rec_q, in_rec_d;

  logic rec_we, ord_we;
  logic [IdxW-1:0] rec_waddr, ord_waddr, ord_wdata, rec_raddr, ord_raddr;
  logic [IdxW-1:0] ord_rdata_q;
  logic [RecW-1:0] rec_rdata_q;
  logic ord_rd_slot;

  logic res_v_d, res_last_d, res_rec_d;
  status_e res_st_d;
  logic res_v_q, res_last_q, res_rec_q;
  status_e res_st_q;
  logic [RecW-1:0] res_data_q;

  logic [IdxW-1:0] swap_addr_q, swap_data_q;
  logic swap_q;

  logic [IdxW-1:0] low_free;
  logic any_free;
  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        low_free = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= in_rec_q;
    rec_rdata_q <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata_q <= ord_mem[ord_raddr];
  end

  logic signed [KeyW-1:0] rd_key;
  assign rd_key = rec_rdata_q[RecW-1 -: KeyW];

  always_comb begin
    state_d = state_q;
    act_d = act_q;
    cnt_d = cnt_q;
    free_d = free_q;
    pos_d = pos_q;
    pos2_d = pos2_q;
    tmp_d = tmp_q;
    new_slot_d = new_slot_q;
    key_d = key_q;
    in_rec_d = in_rec_q;
    rec_we = 1'b0;
    ord_we = 1'b0;
    rec_waddr = new_slot_q;
    ord_waddr = pos_q[IdxW-1:0];
    ord_wdata = new_slot_q;
    ord_raddr = pos_q[IdxW-1:0];
    rec_raddr = ord_rdata_q;
    ord_rd_slot = 1'b0;
    res_v_d = 1'b0;
    res_last_d = 1'b1;
    res_rec_d = 1'b0;
    res_st_d = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        ord_raddr = '0;
        if (start_i && !busy_o) begin
          act_d = action_e'(action_i);
          key_d = key_in_i;
          in_rec_d = {key_in_i, age_in_i, name_in_0_7_i & LowMask,
                      name_in_8_15_i & MidMask, name_in_16_19_i & HighMask};
          pos_d = '0;
          new_slot_d = low_free;
          unique case (action_e'(action_i))
            ACT_APPEND, ACT_INSERT: begin
              if (cnt_q >= CntW'(CAPACITY) || !any_free) begin
                res_st_d = ST_FULL;
                state_d = S_DONE;
              end else if (action_e'(action_i) == ACT_APPEND || cnt_q == '0) begin
                pos_d = cnt_q;
                state_d = S_SHIFT_WR;
                pos2_d = cnt_q;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            ACT_FIND, ACT_REMOVE: begin
              if (cnt_q == '0) begin
                res_st_d = ST_NOT_FOUND;
                state_d = S_DONE;
              end else state_d = S_SCAN_RD;
            end
            ACT_READOUT: begin
              if (cnt_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d = S_DONE;
              end else state_d = S_OUT_RD;
            end
            ACT_REVERSE: begin
              if (cnt_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d = S_DONE;
              end else if (cnt_q < CntW'(2)) begin
                state_d = S_DONE;
              end else begin
                pos2_d = cnt_q - CntW'(1);
                state_d = S_REV_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
          res_v_d = (state_d == S_DONE);
        end
      end
      // Read the order entry, then its record.
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // ord_rdata_q holds the slot; rec_raddr issues the record read now.
        state_d = S_OUT_EMIT;
        tmp_d = ord_rdata_q;
      end
      S_OUT_EMIT: begin
        if (act_q == ACT_READOUT) begin
          res_v_d = 1'b1;
          res_rec_d = 1'b1;
          res_last_d = (pos_q + CntW'(1) == cnt_q);
          if (res_last_d) state_d = S_IDLE;
          else begin
            pos_d = pos_q + CntW'(1);
            state_d = S_OUT_RD;
          end
        end else if (act_q == ACT_INSERT) begin
          if (key_q < rd_key) begin
            pos2_d = cnt_q;
            state_d = (cnt_q == pos_q) ? S_SHIFT_WR : S_SHIFT_RD;
            ord_raddr = IdxW'(cnt_q - CntW'(1));
          end else if (pos_q + CntW'(1) == cnt_q) begin
            pos_d = cnt_q;
            pos2_d = cnt_q;
            state_d = S_SHIFT_WR;
          end else begin
            pos_d = pos_q + CntW'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          if (rd_key == key_q) begin
            if (act_q == ACT_FIND) begin
              res_v_d = 1'b1;
              res_rec_d = 1'b1;
              state_d = S_DONE;
            end else begin
              free_d[tmp_q] = 1'b1;
              pos2_d = pos_q;
              cnt_d = cnt_q - CntW'(1);
              if (pos_q + CntW'(1) == cnt_q) begin
                res_v_d = 1'b1;
                state_d = S_DONE;
              end else begin
                ord_raddr = IdxW'(pos_q + CntW'(1));
                state_d = S_SHIFT_RD;
              end
            end
          end else if (pos_q + CntW'(1) == cnt_q) begin
            res_v_d = 1'b1;
            res_st_d = ST_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            pos_d = pos_q + CntW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_OUT_RD: begin
        state_d = S_SCAN_CHK;
      end
      // Insert moves entries up from the tail; remove moves them down.
      S_SHIFT_RD: begin
        ord_we = 1'b1;
        if (act_q == ACT_INSERT) begin
          ord_waddr = IdxW'(pos2_q);
          ord_wdata = ord_rdata_q;
          pos2_d = pos2_q - CntW'(1);
          if (pos2_q - CntW'(1) == pos_q) state_d = S_SHIFT_WR;
          else ord_raddr = IdxW'(pos2_q - CntW'(2));
        end else begin
          ord_waddr = IdxW'(pos2_q);
          ord_wdata = ord_rdata_q;
          pos2_d = pos2_q + CntW'(1);
          if (pos2_q + CntW'(1) == cnt_q) begin
            res_v_d = 1'b1;
            state_d = S_DONE;
          end else ord_raddr = IdxW'(pos2_q + CntW'(2));
        end
      end
      S_SHIFT_WR: begin
        ord_we = 1'b1;
        ord_waddr = pos_q[IdxW-1:0];
        ord_wdata = new_slot_q;
        rec_we = 1'b1;
        free_d[new_slot_q] = 1'b0;
        cnt_d = cnt_q + CntW'(1);
        res_v_d = 1'b1;
        state_d = S_DONE;
      end
      S_REV_RD: begin
        ord_raddr = pos2_q[IdxW-1:0];
        tmp_d = ord_rdata_q;
        state_d = S_REV_WR;
      end
      S_REV_WR: begin
        ord_we = 1'b1;
        ord_waddr = pos_q[IdxW-1:0];
        ord_wdata = ord_rdata_q;
        pos_d = pos_q + CntW'(1);
        pos2_d = pos2_q - CntW'(1);
        state_d = S_DONE;
        if (pos_q + CntW'(1) < pos2_q - CntW'(1)) begin
          state_d = S_REV_RD;
          ord_raddr = IdxW'(pos_q + CntW'(1));
        end else res_v_d = 1'b1;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // The second half of a swap writes the saved head-side slot at the tail
    // side in the cycle after the tail-side slot is written at the head side.
    if (swap_q) begin
      ord_we = 1'b1;
      ord_waddr = swap_addr_q;
      ord_wdata = swap_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= ACT_APPEND;
      cnt_q <= '0;
      free_q <= '1;
      pos_q <= '0;
      pos2_q <= '0;
      res_v_q <= 1'b0;
      swap_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q <= act_d;
      cnt_q <= cnt_d;
      free_q <= free_d;
      pos_q <= pos_d;
      pos2_q <= pos2_d;
      res_v_q <= res_v_d;
      swap_q <= (state_q == S_REV_WR);
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    new_slot_q <= new_slot_d;
    key_q <= key_d;
    in_rec_q <= in_rec_d;
    res_last_q <= res_last_d;
    res_rec_q <= res_rec_d;
    res_st_q <= res_st_d;
    res_data_q <= rec_rdata_q;
    swap_addr_q <= pos2_q[IdxW-1:0];
    swap_data_q <= tmp_q;
  end

  logic unused_rd;
  assign unused_rd = ord_rd_slot;

  assign busy_o = (state_q != S_IDLE) || res_v_q || swap_q || unused_rd;
  assign result_valid_o = res_v_q;
  assign status_o = res_st_q;
  assign key_out_o = res_rec_q ? res_data_q[RecW-1 -: KeyW] : '0;
  assign age_out_o = res_rec_q ? res_data_q[RecW-KeyW-1 -: AgeW] : '0;
  assign name_out_0_7_o = res_rec_q ? res_data_q[NameMidW+NameHighW +: NameLowW] : '0;
  assign name_out_8_15_o = res_rec_q ? res_data_q[NameHighW +: NameMidW] : '0;
  assign name_out_16_19_o = res_rec_q ? res_data_q[0 +: NameHighW] : '0;
  assign last_item_o = res_last_q;
  assign stored_count_o = 5'(cnt_q);
  assign is_empty_o = (cnt_q == '0);

endmodule
